>>> hw/rtl/garage_door_state_tracker_core_assert.svh
// Assertion macros used by the checker file of the door tracker.
`ifndef GARAGE_DOOR_STATE_TRACKER_CORE_ASSERT_SVH
`define GARAGE_DOOR_STATE_TRACKER_CORE_ASSERT_SVH

// Clocked check, disabled while the active-low reset is asserted.
`define GDST_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define GDST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/gdst_pkg.sv
package gdst_pkg;

  // Door position codes as reported on the result stream.
  typedef enum logic [2:0] {
    DOOR_OPEN    = 3'd0,
    DOOR_CLOSED  = 3'd1,
    DOOR_OPENING = 3'd2,
    DOOR_CLOSING = 3'd3,
    DOOR_STOPPED = 3'd4
  } door_state_e;

  localparam logic TGT_OPEN   = 1'b0;
  localparam logic TGT_CLOSED = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OBST_POL = 2'd2;

  localparam logic [15:0] DEBOUNCE_RST = 16'd250;
  localparam logic [31:0] TIMEOUT_RST  = 32'd30000;

  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 8;

  // Debounced switch view: level before and after this item, and a change flag.
  typedef struct packed {
    logic cur;
    logic nxt;
    logic chg;
  } sw_evt_t;

  // Deadline timer control from the door logic.
  typedef struct packed {
    logic adv;
    logic arm;
    logic clear;
  } dl_ctrl_t;

endpackage

>>> hw/rtl/gdst_debounce.sv
module gdst_debounce import gdst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        seed_i,
  input  logic        adv_i,
  input  logic        raw_i,
  input  logic [15:0] limit_i,
  output sw_evt_t     evt_o
);

  logic        level_q, level_d;
  logic [15:0] cnt_q, cnt_d;
  logic        chg;

  always_comb begin
    level_d = level_q;
    cnt_d   = cnt_q;
    chg     = 1'b0;
    if (seed_i) begin
      level_d = raw_i;
      cnt_d   = '0;
    end else if (adv_i) begin
      if (raw_i == level_q) begin
        cnt_d = '0;
      end else if (cnt_q >= limit_i) begin
        level_d = raw_i;
        cnt_d   = '0;
        chg     = 1'b1;
      end else begin
        cnt_d = cnt_q + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      level_q <= level_d;
      cnt_q   <= cnt_d;
    end
  end

  assign evt_o.cur = level_q;
  assign evt_o.nxt = level_d;
  assign evt_o.chg = chg;

endmodule

>>> hw/rtl/gdst_deadline.sv
module gdst_deadline import gdst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dl_ctrl_t    ctrl_i,
  input  logic [31:0] timeout_i,
  output logic        due_o
);

  logic        active_q, active_d;
  logic [31:0] cnt_q, cnt_d;

  // Expired: armed and counted out; stays pending until cleared.
  assign due_o = ctrl_i.adv && active_q && (cnt_q == '0);

  always_comb begin
    active_d = active_q;
    cnt_d    = cnt_q;
    if (ctrl_i.arm) begin
      active_d = 1'b1;
      cnt_d    = timeout_i;
    end else if (ctrl_i.adv) begin
      if (ctrl_i.clear) begin
        active_d = 1'b0;
        cnt_d    = '0;
      end else if (active_q && (cnt_q != '0)) begin
        cnt_d = cnt_q - 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

>>> hw/rtl/garage_door_state_tracker_core.sv
// Garage door state tracker. Each input transfer is either a millisecond tick
// (tuser 0) carrying the raw open, closed and obstruction switch levels, or a
// door command (tuser 1) carrying the requested target and the relay pulse
// length. Every input transfer yields exactly one result transfer with the
// door position, target, obstruction flag, relay drive and a status-changed
// flag. The first tick after reset only seeds the debounced levels and door
// state. Rate: one item per clock cycle sustained while results are taken;
// each item passes the input register, then the single-pass update logic
// feeding the result register, before its result is presented. While a
// finished result waits, the input register still takes one more item;
// after that s_axis_tready_o drops until the waiting result transfers.
// Configuration writes (debounce interval, move timeout, obstruction
// polarity) take effect at once and must only be issued while no item is
// in flight.
module garage_door_state_tracker_core import gdst_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // tdata, low bit up: open_switch_raw, closed_switch_raw, obstruction_raw,
  // requested_target, contact_time[15:0], 4 zero pad bits
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // tuser: func (0 tick, 1 command)
  input  logic                  s_axis_tuser_i,
  // Result stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // tdata, low bit up: door_current[2:0], door_target, obstruction_seen,
  // relay_on, status_changed, 1 zero pad bit
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // Configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [31:0]           cfg_wdata_i
);

  // ---------------------------------------------------------------- config
  logic [15:0] debounce_q;
  logic [31:0] timeout_q;
  logic        pol_q;

  // ---------------------------------------------------------- input stage
  logic                 in_valid_q;
  logic [IN_DATA_W-1:0] in_data_q;
  logic                 in_func_q;
  logic                 proc_fire;

  // Advance the item held in the input register when the result register
  // is empty or being drained this cycle.
  assign proc_fire       = in_valid_q && (!m_axis_tvalid_o || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || proc_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_data_q <= s_axis_tdata_i;
      in_func_q <= s_axis_tuser_i;
    end
  end

  // Unpack the held item.
  logic        raw_open, raw_closed, raw_obst, req_tgt;
  logic [15:0] pulse;
  assign raw_open   = in_data_q[0];
  assign raw_closed = in_data_q[1];
  assign raw_obst   = in_data_q[2];
  assign req_tgt    = in_data_q[3];
  assign pulse      = in_data_q[19:4];

  // ------------------------------------------------------- item decoding
  logic seeded_q, seeded_d;
  logic tick, cmd, seed, adv;

  assign tick = proc_fire && !in_func_q;
  assign cmd  = proc_fire && in_func_q;
  assign seed = tick && !seeded_q;
  assign adv  = tick && seeded_q;

  // ------------------------------------------------------------ debounce
  sw_evt_t ev_open, ev_closed, ev_obst;

  gdst_debounce u_db_open (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .seed_i  (seed),
    .adv_i   (adv),
    .raw_i   (raw_open),
    .limit_i (debounce_q),
    .evt_o   (ev_open)
  );

  gdst_debounce u_db_closed (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .seed_i  (seed),
    .adv_i   (adv),
    .raw_i   (raw_closed),
    .limit_i (debounce_q),
    .evt_o   (ev_closed)
  );

  gdst_debounce u_db_obst (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .seed_i  (seed),
    .adv_i   (adv),
    .raw_i   (raw_obst),
    .limit_i (debounce_q),
    .evt_o   (ev_obst)
  );

  // ----------------------------------------------------------- deadlines
  dl_ctrl_t close_ctrl, open_ctrl;
  logic     close_due, open_due;

  gdst_deadline u_dl_close (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (close_ctrl),
    .timeout_i (timeout_q),
    .due_o     (close_due)
  );

  gdst_deadline u_dl_open (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (open_ctrl),
    .timeout_i (timeout_q),
    .due_o     (open_due)
  );

  // ---------------------------------------------------------- door logic
  door_state_e cur_q, cur_d;
  logic        tgt_q, tgt_d;
  logic        obst_q, obst_d;
  logic [15:0] relay_q, relay_d;
  logic        changed;
  logic        arm_close, arm_open, clr_close, clr_open;

  always_comb begin
    cur_d     = cur_q;
    tgt_d     = tgt_q;
    obst_d    = obst_q;
    relay_d   = relay_q;
    seeded_d  = seeded_q;
    changed   = 1'b0;
    arm_close = 1'b0;
    arm_open  = 1'b0;
    clr_close = 1'b0;
    clr_open  = 1'b0;

    if (seed) begin
      // First tick: take raw levels as settled and derive the door state.
      seeded_d = 1'b1;
      if (raw_open) begin
        cur_d = DOOR_OPEN;
        tgt_d = TGT_OPEN;
      end else if (raw_closed) begin
        cur_d = DOOR_CLOSED;
        tgt_d = TGT_CLOSED;
      end else begin
        cur_d = DOOR_STOPPED;
        tgt_d = TGT_OPEN;
      end
      if (raw_obst ^ pol_q) begin
        obst_d = 1'b1;
      end
    end else if (adv) begin
      if (relay_q != '0) begin
        relay_d = relay_q - 16'd1;
      end
      // Switch edges; the closed switch wins over the open switch.
      if (ev_open.chg) begin
        changed = 1'b1;
        if (ev_open.nxt) begin
          cur_d = DOOR_OPEN;
          tgt_d = TGT_OPEN;
        end else begin
          cur_d = DOOR_CLOSING;
          tgt_d = TGT_CLOSED;
        end
      end
      if (ev_closed.chg) begin
        changed = 1'b1;
        if (ev_closed.nxt) begin
          cur_d = DOOR_CLOSED;
          tgt_d = TGT_CLOSED;
        end else begin
          cur_d = DOOR_OPENING;
          tgt_d = TGT_OPEN;
        end
      end
      if (ev_obst.chg) begin
        changed = 1'b1;
        obst_d  = ev_obst.nxt ^ pol_q;
      end
      // Move timeouts: force a settled position from the open/closed switch.
      if (close_due && (cur_d == DOOR_CLOSING)) begin
        clr_close = 1'b1;
        changed   = 1'b1;
        cur_d     = ev_open.nxt ? DOOR_OPEN : DOOR_CLOSED;
      end
      if (open_due && (cur_d == DOOR_OPENING)) begin
        clr_open = 1'b1;
        changed  = 1'b1;
        cur_d    = ev_closed.nxt ? DOOR_CLOSED : DOOR_OPEN;
      end
    end else if (cmd) begin
      changed = 1'b1;
      priority if ((cur_q == DOOR_OPENING) || (cur_q == DOOR_CLOSING)) begin
        // Stop while moving.
        relay_d = pulse;
        if (ev_closed.cur) begin
          cur_d = DOOR_CLOSED;
          tgt_d = TGT_CLOSED;
        end else if (ev_open.cur) begin
          cur_d = DOOR_OPEN;
          tgt_d = TGT_OPEN;
        end else begin
          cur_d = DOOR_STOPPED;
        end
      end else if ((req_tgt == TGT_OPEN) && ev_open.cur) begin
        cur_d = DOOR_OPEN;
        tgt_d = TGT_OPEN;
      end else if ((req_tgt == TGT_CLOSED) && ev_closed.cur) begin
        cur_d = DOOR_CLOSED;
        tgt_d = TGT_CLOSED;
      end else begin
        relay_d = pulse;
        if (cur_q == DOOR_STOPPED) begin
          // Toggle direction from a stopped door.
          if (tgt_q == TGT_OPEN) begin
            tgt_d     = TGT_CLOSED;
            cur_d     = DOOR_CLOSING;
            arm_close = 1'b1;
          end else begin
            tgt_d    = TGT_OPEN;
            cur_d    = DOOR_OPENING;
            arm_open = 1'b1;
          end
        end else if (req_tgt == TGT_OPEN) begin
          tgt_d    = TGT_OPEN;
          cur_d    = DOOR_OPENING;
          arm_open = 1'b1;
        end else begin
          tgt_d     = TGT_CLOSED;
          cur_d     = DOOR_CLOSING;
          arm_close = 1'b1;
        end
      end
    end
  end

  assign close_ctrl = '{adv: adv, arm: arm_close, clear: clr_close};
  assign open_ctrl  = '{adv: adv, arm: arm_open,  clear: clr_open};

  // State and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q      <= DOOR_STOPPED;
      tgt_q      <= TGT_OPEN;
      obst_q     <= 1'b0;
      relay_q    <= '0;
      seeded_q   <= 1'b0;
      debounce_q <= DEBOUNCE_RST;
      timeout_q  <= TIMEOUT_RST;
      pol_q      <= 1'b0;
    end else begin
      cur_q    <= cur_d;
      tgt_q    <= tgt_d;
      relay_q  <= relay_d;
      seeded_q <= seeded_d;
      if (cfg_we_i && (cfg_idx_i == CFG_OBST_POL)) begin
        // Re-evaluate the tracked flag through the new polarity.
        obst_q <= ev_obst.cur ^ cfg_wdata_i[0];
      end else begin
        obst_q <= obst_d;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_DEBOUNCE: debounce_q <= cfg_wdata_i[15:0];
          CFG_TIMEOUT:  timeout_q  <= cfg_wdata_i;
          CFG_OBST_POL: pol_q      <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  // -------------------------------------------------------- result stage
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire) begin
      out_data_q <= {1'b0, changed, (relay_d != '0), obst_d, tgt_d, cur_d};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

>>> hw/rtl/gdst_checker.sv
`include "garage_door_state_tracker_core_assert.svh"

module gdst_checker import gdst_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  // A stalled result holds its valid and data.
  `GDST_ASSERT(a_out_hold, clk_i, rst_ni, (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)), "result changed while stalled")

  // After every input transfer a valid result is offered; under back-pressure it may be an older result still waiting.
  `GDST_ASSERT(a_latency, clk_i, rst_ni, (s_axis_tvalid_i && s_axis_tready_o) |-> ##2 m_axis_tvalid_o, "no result after input transfer")

  // The reported door position is always a defined code.
  `GDST_ASSERT(a_door_code, clk_i, rst_ni, m_axis_tvalid_o |-> (m_axis_tdata_o[2:0] <= DOOR_STOPPED), "undefined door position code")

  // No result is offered right out of reset.
  `GDST_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !m_axis_tvalid_o, "result valid after reset")

endmodule

bind garage_door_state_tracker_core gdst_checker u_gdst_checker (.*);

>>> verif/tb_top.sv
module tb_top;
  import gdst_pkg::*;

  // Register index past the end of the list; the block must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // Switch slots in the debounce arrays.
  localparam int SW_OPEN   = 0;
  localparam int SW_CLOSED = 1;
  localparam int SW_OBST   = 2;

  // Cycles without any transfer before the run is declared hung.
  localparam int QUIET_LIMIT  = 500;
  localparam int REPORT_MAX   = 10;
  // Result count at which the sink holds off, and for how many cycles.
  localparam int PRESSURE_AT  = 200;
  localparam int PRESSURE_LEN = 48;

  // One input item, as the block sees it before packing.
  typedef struct packed {
    logic        is_cmd;
    logic        open_raw;
    logic        closed_raw;
    logic        obst_raw;
    logic        target;
    logic [15:0] pulse;
  } door_item_t;

  // Result layout matches m_axis_tdata_o from the low bit up.
  typedef struct packed {
    logic        pad;
    logic        status_chg;
    logic        relay_on;
    logic        obst;
    logic        goal;
    door_state_e pos;
  } door_status_t;

  typedef enum logic [1:0] {EDGE_NONE, EDGE_PRESS, EDGE_RELEASE} sw_edge_e;
  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  // One line of the directed table: either an item or a register write.
  typedef struct packed {
    row_kind_e            kind;
    door_item_t           item;
    logic                 has_exp;
    door_status_t         exp;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [31:0]          cfg_val;
  } script_row_t;

  // One register setting of the random part.
  typedef struct packed {
    logic [15:0] debounce;
    logic [31:0] timeout;
    logic        obst_low;
    logic [15:0] n_items;
    logic        no_idle;
  } setting_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and the block's ports
  // ---------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [31:0]           cfg_wdata = '0;

  always #5 clk = ~clk;

  garage_door_state_tracker_core uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Door tracker state as the testbench sees it
  // ---------------------------------------------------------------------------
  logic [15:0]  debounce_set;
  logic [31:0]  timeout_set;
  logic         obst_low_set;
  door_state_e  door_pos;
  logic         door_goal;
  logic         obst_flag;
  logic [2:0]   sw_level;
  logic [15:0]  sw_count [3];
  logic [31:0]  close_left;
  logic [31:0]  open_left;
  logic         close_armed;
  logic         open_armed;
  logic [15:0]  relay_left;
  logic         seeded;

  // Door statuses still owed by the block, oldest first.
  door_status_t pending_status[$];

  // Physical switch levels that the random ticks drift around.
  logic phys_open = 1'b0;
  logic phys_closed = 1'b0;
  logic phys_obst = 1'b0;

  logic idle_on = 1'b1;
  logic pressure_done = 1'b0;
  int   n_items = 0;
  int   n_cmds = 0;
  int   n_results = 0;
  int   n_changes = 0;
  int   n_forced = 0;
  int   n_settings = 0;
  int   n_fail = 0;
  int   quiet_cycles = 0;

  // Pressed view of a debounced switch; the obstruction sensor honors its polarity.
  function automatic logic sw_pressed(int sw);
    if (sw == SW_OBST) return sw_level[sw] ^ obst_low_set;
    return sw_level[sw];
  endfunction

  // Count a differing raw level up; accept it once the count has reached the interval.
  function automatic sw_edge_e sw_debounce(int sw, logic raw);
    logic was;
    if (raw == sw_level[sw]) begin
      sw_count[sw] = '0;
      return EDGE_NONE;
    end
    if (sw_count[sw] >= debounce_set) begin
      was = sw_pressed(sw);
      sw_level[sw] = raw;
      sw_count[sw] = '0;
      return was ? EDGE_RELEASE : EDGE_PRESS;
    end
    sw_count[sw] = sw_count[sw] + 16'd1;
    return EDGE_NONE;
  endfunction

  // Advance the tracker by one item and return the status it reports.
  function automatic door_status_t next_status(door_item_t it);
    door_status_t st;
    sw_edge_e     eo, ec, eb;
    logic         chg, due, go_close;
    chg = 1'b0;
    if (it.is_cmd) begin
      chg = 1'b1;
      if (door_pos == DOOR_OPENING || door_pos == DOOR_CLOSING) begin
        // Stop a moving door; a pressed end switch tells where it really is.
        if (sw_pressed(SW_CLOSED)) begin
          door_pos = DOOR_CLOSED;
          door_goal = TGT_CLOSED;
        end else if (sw_pressed(SW_OPEN)) begin
          door_pos = DOOR_OPEN;
          door_goal = TGT_OPEN;
        end else begin
          door_pos = DOOR_STOPPED;
        end
        relay_left = it.pulse;
      end else if (it.target == TGT_OPEN && sw_pressed(SW_OPEN)) begin
        // Already open: no relay pulse.
        door_pos = DOOR_OPEN;
        door_goal = TGT_OPEN;
      end else if (it.target == TGT_CLOSED && sw_pressed(SW_CLOSED)) begin
        door_pos = DOOR_CLOSED;
        door_goal = TGT_CLOSED;
      end else begin
        // From stopped the request is ignored and the last target is reversed.
        if (door_pos == DOOR_STOPPED) go_close = (door_goal == TGT_OPEN);
        else go_close = (it.target == TGT_CLOSED);
        if (go_close) begin
          door_goal = TGT_CLOSED;
          door_pos = DOOR_CLOSING;
          close_left = timeout_set;
          close_armed = 1'b1;
        end else begin
          door_goal = TGT_OPEN;
          door_pos = DOOR_OPENING;
          open_left = timeout_set;
          open_armed = 1'b1;
        end
        relay_left = it.pulse;
      end
    end else if (!seeded) begin
      // First tick: load the levels as debounced and seed the position and obstruction flag, nothing else.
      seeded = 1'b1;
      sw_level = {it.obst_raw, it.closed_raw, it.open_raw};
      sw_count = '{default: '0};
      if (sw_pressed(SW_OPEN)) begin
        door_pos = DOOR_OPEN;
        door_goal = TGT_OPEN;
      end else if (sw_pressed(SW_CLOSED)) begin
        door_pos = DOOR_CLOSED;
        door_goal = TGT_CLOSED;
      end else begin
        door_pos = DOOR_STOPPED;
        door_goal = TGT_OPEN;
      end
      if (sw_pressed(SW_OBST)) obst_flag = 1'b1;
    end else begin
      if (relay_left != '0) relay_left = relay_left - 16'd1;
      eo = sw_debounce(SW_OPEN, it.open_raw);
      ec = sw_debounce(SW_CLOSED, it.closed_raw);
      eb = sw_debounce(SW_OBST, it.obst_raw);
      // Later edges override earlier ones in this fixed order.
      if (eo == EDGE_RELEASE) begin
        door_pos = DOOR_CLOSING;
        door_goal = TGT_CLOSED;
        chg = 1'b1;
      end
      if (eo == EDGE_PRESS) begin
        door_pos = DOOR_OPEN;
        door_goal = TGT_OPEN;
        chg = 1'b1;
      end
      if (ec == EDGE_RELEASE) begin
        door_pos = DOOR_OPENING;
        door_goal = TGT_OPEN;
        chg = 1'b1;
      end
      if (ec == EDGE_PRESS) begin
        door_pos = DOOR_CLOSED;
        door_goal = TGT_CLOSED;
        chg = 1'b1;
      end
      if (eb == EDGE_PRESS) begin
        obst_flag = 1'b1;
        chg = 1'b1;
      end
      if (eb == EDGE_RELEASE) begin
        obst_flag = 1'b0;
        chg = 1'b1;
      end
      // An expired deadline stays pending until the door is seen moving its way.
      due = 1'b0;
      if (close_armed) begin
        if (close_left == '0) due = 1'b1;
        else close_left = close_left - 32'd1;
      end
      if (due && door_pos == DOOR_CLOSING) begin
        close_armed = 1'b0;
        close_left = '0;
        if (sw_pressed(SW_OPEN)) door_pos = DOOR_OPEN;
        else door_pos = DOOR_CLOSED;
        chg = 1'b1;
        n_forced++;
      end
      due = 1'b0;
      if (open_armed) begin
        if (open_left == '0) due = 1'b1;
        else open_left = open_left - 32'd1;
      end
      if (due && door_pos == DOOR_OPENING) begin
        open_armed = 1'b0;
        open_left = '0;
        if (sw_pressed(SW_CLOSED)) door_pos = DOOR_CLOSED;
        else door_pos = DOOR_OPEN;
        chg = 1'b1;
        n_forced++;
      end
    end
    st.pad = 1'b0;
    st.pos = door_pos;
    st.goal = door_goal;
    st.obst = obst_flag;
    st.relay_on = (relay_left != '0);
    st.status_chg = chg;
    return st;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table rows
  // ---------------------------------------------------------------------------
  function automatic script_row_t tick_row(logic o, logic c, logic b);
    script_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.item.open_raw = o;
    r.item.closed_raw = c;
    r.item.obst_raw = b;
    return r;
  endfunction

  function automatic script_row_t cmd_row(logic tgt, logic [15:0] pulse);
    script_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.item.is_cmd = 1'b1;
    r.item.target = tgt;
    r.item.pulse = pulse;
    return r;
  endfunction

  function automatic script_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    script_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.cfg_idx = idx;
    r.cfg_val = val;
    return r;
  endfunction

  // Attach a status typed in by hand to an item row.
  function automatic script_row_t checked(script_row_t r, door_state_e pos, logic goal,
                                          logic obst, logic relay, logic chg);
    r.has_exp = 1'b1;
    r.exp = '{1'b0, chg, relay, obst, goal, pos};
    return r;
  endfunction

  // Random item: mostly ticks that follow a door traveling between its end switches,
  // some commands, and some one-tick glitches on every raw line.
  function automatic door_item_t random_item();
    door_item_t it;
    int         roll;
    it = '0;
    roll = $urandom_range(0, 99);
    it.open_raw = 1'($urandom);
    it.closed_raw = 1'($urandom);
    it.obst_raw = 1'($urandom);
    it.target = 1'($urandom);
    it.pulse = 16'($urandom);
    if (roll < 15) begin
      it.is_cmd = 1'b1;
      if ($urandom_range(0, 7) != 0) it.pulse = 16'($urandom_range(0, 12));
    end else if (roll >= 22) begin
      if ($urandom_range(0, 9) == 0) begin
        // Leave an end switch, or arrive at one.
        if (phys_open || phys_closed) begin
          phys_open = 1'b0;
          phys_closed = 1'b0;
        end else if ($urandom_range(0, 1) == 0) begin
          phys_open = 1'b1;
        end else begin
          phys_closed = 1'b1;
        end
      end
      if ($urandom_range(0, 14) == 0) phys_obst = ~phys_obst;
      it.open_raw = phys_open;
      it.closed_raw = phys_closed;
      it.obst_raw = phys_obst;
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers: inputs change on the falling edge, handshakes are taken at the rising edge
  // ---------------------------------------------------------------------------

  // Offer one item, hold it until the transfer, and record what the block owes for it.
  task automatic drive_item(input door_item_t it, input logic has_exp,
                            input door_status_t exp);
    int           gap;
    door_status_t want;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.is_cmd;
    s_axis_tdata <= {4'b0, it.pulse, it.target, it.obst_raw, it.closed_raw, it.open_raw};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    want = next_status(it);
    pending_status.push_back(has_exp ? exp : want);
    n_items++;
    if (it.is_cmd) n_cmds++;
    if (want.status_chg) n_changes++;
    @(negedge clk);
  endtask

  // Drop the input, wait until every owed status has arrived, then let the pipe drain.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write one register and mirror it in the tracker state.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_DEBOUNCE: debounce_set = val[15:0];
      CFG_TIMEOUT:  timeout_set = val;
      CFG_OBST_POL: begin
        // New polarity re-derives the obstruction flag from the debounced level.
        obst_low_set = val[0];
        obst_flag = sw_pressed(SW_OBST);
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result sink: random back-pressure, one long hold-off, field-by-field check
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int           gap;
    door_status_t got;
    door_status_t want;
    @(posedge rst_n);
    forever begin
      gap = idle_on ? $urandom_range(0, 6) : 0;
      // Hold off long enough once for the block to fill and stall its input.
      if (!pressure_done && n_results == PRESSURE_AT) begin
        gap = PRESSURE_LEN;
        pressure_done = 1'b1;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      got = m_axis_tdata;
      n_results++;
      if (pending_status.size() == 0) begin
        n_fail++;
        if (n_fail <= REPORT_MAX)
          $display("unexpected status transfer %0d: pos=%0d goal=%0b obst=%0b relay=%0b chg=%0b",
                   n_results, got.pos, got.goal, got.obst, got.relay_on, got.status_chg);
      end else begin
        want = pending_status.pop_front();
        if (got.pos !== want.pos || got.goal !== want.goal || got.obst !== want.obst ||
            got.relay_on !== want.relay_on || got.status_chg !== want.status_chg) begin
          n_fail++;
          if (n_fail <= REPORT_MAX) begin
            $display("status %0d mismatch: expected pos=%0d goal=%0b obst=%0b relay=%0b chg=%0b",
                     n_results, want.pos, want.goal, want.obst, want.relay_on, want.status_chg);
            $display("                     actual pos=%0d goal=%0b obst=%0b relay=%0b chg=%0b",
                     got.pos, got.goal, got.obst, got.relay_on, got.status_chg);
          end
        end
      end
      @(negedge clk);
    end
  end

  // Watchdog: count cycles with no transfer and no register write.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d statuses owed",
               quiet_cycles, pending_status.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    script_row_t script[$];
    setting_t    settings[7];

    // Tracker state right after reset.
    debounce_set = DEBOUNCE_RST;
    timeout_set = TIMEOUT_RST;
    obst_low_set = 1'b0;
    door_pos = DOOR_STOPPED;
    door_goal = TGT_OPEN;
    obst_flag = 1'b0;
    sw_level = '0;
    sw_count = '{default: '0};
    close_left = '0;
    open_left = '0;
    close_armed = 1'b0;
    open_armed = 1'b0;
    relay_left = '0;
    seeded = 1'b0;

    // Directed table. The first two rows run on reset settings and carry
    // hand-typed statuses; the rest are checked against the tracker state.
    // Command before the seeding tick works on the all-released reset levels.
    script.push_back(checked(cmd_row(TGT_CLOSED, 16'd3), DOOR_CLOSING, TGT_CLOSED,
                             1'b0, 1'b1, 1'b1));
    // Seeding tick: open pressed, obstruction high; relay count still running, no status change.
    script.push_back(checked(tick_row(1'b1, 1'b0, 1'b1), DOOR_OPEN, TGT_OPEN,
                             1'b1, 1'b1, 1'b0));
    script.push_back(cfg_row(CFG_DEBOUNCE, 32'd0));
    script.push_back(cfg_row(CFG_TIMEOUT, 32'd1));
    script.push_back(cfg_row(CFG_OBST_POL, 32'd1));
    script.push_back(cfg_row(CFG_UNUSED, 32'hFFFF_FFFF));
    script.push_back(tick_row(1'b0, 1'b0, 1'b1));     // open released: closing
    script.push_back(tick_row(1'b0, 1'b1, 1'b0));     // closed pressed, obstruction low
    script.push_back(cmd_row(TGT_CLOSED, 16'd5));     // already closed
    script.push_back(cmd_row(TGT_OPEN, 16'd0));       // open with zero pulse
    script.push_back(tick_row(1'b0, 1'b0, 1'b0));     // closed released: opening
    script.push_back(tick_row(1'b0, 1'b0, 1'b0));     // open deadline forces a position
    script.push_back(cmd_row(TGT_CLOSED, 16'hFFFF));  // close with longest pulse
    script.push_back(cmd_row(TGT_OPEN, 16'd2));       // stop while moving
    script.push_back(cmd_row(TGT_OPEN, 16'd1));       // toggle from stopped
    script.push_back(cmd_row(TGT_CLOSED, 16'd4));     // stop again
    script.push_back(cmd_row(TGT_OPEN, 16'd4));       // toggle reverses the last target
    script.push_back(tick_row(1'b0, 1'b0, 1'b0));
    script.push_back(tick_row(1'b0, 1'b0, 1'b0));     // close deadline forces a position
    script.push_back(tick_row(1'b1, 1'b1, 1'b1));     // both end switches at once
    script.push_back(cmd_row(TGT_OPEN, 16'd7));       // already open
    script.push_back(tick_row(1'b1, 1'b1, 1'b1));     // steady: no change
    script.push_back(cfg_row(CFG_OBST_POL, 32'd0));
    script.push_back(tick_row(1'b0, 1'b0, 1'b0));

    // Random part: short intervals so edges and deadlines fire often, plus both extremes.
    settings[0] = '{16'd1, 32'd3, 1'b0, 16'd70, 1'b0};
    settings[1] = '{16'd0, 32'd0, 1'b1, 16'd60, 1'b0};
    settings[2] = '{16'hFFFF, 32'hFFFF_FFFF, 1'b0, 16'd30, 1'b1};
    settings[3] = '{16'd2, 32'd6, 1'b1, 16'd70, 1'b1};
    settings[4] = '{16'd3, 32'd1, 1'b0, 16'd70, 1'b0};
    settings[5] = '{16'($urandom_range(0, 4)), 32'($urandom_range(0, 8)), 1'($urandom),
                    16'd70, 1'b0};
    settings[6] = '{16'd1, 32'd2, 1'b1, 16'd60, 1'b0};

    // Hold reset, then release it on a falling edge.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        settle();
        write_reg(script[i].cfg_idx, script[i].cfg_val);
      end else begin
        drive_item(script[i].item, script[i].has_exp, script[i].exp);
      end
    end

    foreach (settings[p]) begin
      settle();
      idle_on = !settings[p].no_idle;
      write_reg(CFG_DEBOUNCE, {16'd0, settings[p].debounce});
      write_reg(CFG_TIMEOUT, settings[p].timeout);
      write_reg(CFG_OBST_POL, {31'd0, settings[p].obst_low});
      repeat (settings[p].n_items) drive_item(random_item(), 1'b0, '0);
      n_settings++;
    end

    settle();
    $display("covered %0d transfers (%0d commands) over %0d register settings plus table",
             n_items, n_cmds, n_settings);
    $display("predicted %0d status changes, %0d positions forced by a move deadline",
             n_changes, n_forced);
    if (n_fail == 0 && pending_status.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d failures, %0d statuses never arrived", n_fail, pending_status.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
